// ===== rtl/rbnh_pkg.sv =====
// Shared constants and types for the ray versus box nearest-hit block.
package rbnh_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int MAX_DIST_INT    = 100;
    localparam int CFG_IDX_W       = 3;
    localparam int NUM_AXES        = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5,
        REG_MAX_DIST = 3'd6
    } t_reg_idx;

endpackage

// ===== rtl/rbnh_recip.sv =====
// Shared restoring divider that forms the per-axis reciprocal of direction plus one LSB.
module rbnh_recip
    import rbnh_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic signed [COORD_WIDTH-1:0] i_dir [NUM_AXES],
    input  logic [NUM_AXES-1:0]           i_dir_wr,
    output logic signed [COORD_WIDTH-1:0] o_inv [NUM_AXES],
    output logic                          o_busy
);

    localparam int W  = COORD_WIDTH;
    localparam int QW = 2 * FRAC_BITS + 1;
    localparam int SW = ((QW > W) ? QW : W) + 1;
    localparam int CW = $clog2(QW);
    localparam int AW = $clog2(NUM_AXES);
    localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [SW-1:0] CMAX_X = {{(SW-W){1'b0}}, CMAX};

    logic [NUM_AXES-1:0] r_pend;
    logic [NUM_AXES-1:0] n_pend;
    logic                r_run;
    logic [AW-1:0]       r_axis;
    logic [AW-1:0]       n_axis;
    logic [CW-1:0]       r_cnt;
    logic [W-1:0]        r_rem;
    logic [QW-1:0]       r_quo;
    logic [W-1:0]        r_mag;
    logic                r_neg;
    logic                r_zero;

    logic signed [W:0] den;
    logic [W:0]        den_abs;
    logic [W:0]        rem_sh;
    logic              ge;
    logic [W-1:0]      n_rem;
    logic [QW-1:0]     n_quo;
    logic [SW-1:0]     quo_x;
    logic [W-1:0]      quo_neg;
    logic [W-1:0]      result;
    logic              start;
    logic              last_step;
    logic [NUM_AXES-1:0] clr;

    always_comb begin
        n_axis = '0;
        for (int i = NUM_AXES - 1; i >= 0; i--) begin
            if (r_pend[i]) begin
                n_axis = AW'(i);
            end
        end
    end

    assign start     = !r_run && (|r_pend);
    assign last_step = r_run && (r_cnt == CW'(QW - 1));
    assign clr       = start ? (NUM_AXES'(1) << n_axis) : '0;
    assign n_pend    = (r_pend & ~clr) | i_dir_wr;

    assign den     = {i_dir[n_axis][W-1], i_dir[n_axis]} + {{W{1'b0}}, 1'b1};
    assign den_abs = den[W] ? ((W+1)'(0) - den) : den;

    assign rem_sh = {r_rem, (r_cnt == '0)};
    assign ge     = rem_sh >= {1'b0, r_mag};
    assign n_rem  = ge ? W'(rem_sh - {1'b0, r_mag}) : rem_sh[W-1:0];
    assign n_quo  = {r_quo[QW-2:0], ge};

    assign quo_x   = {{(SW-QW){1'b0}}, n_quo};
    assign quo_neg = W'(0) - quo_x[W-1:0];

    always_comb begin
        if (r_zero) begin
            result = CMAX;
        end else if (r_neg) begin
            result = (quo_x > CMAX_X + SW'(1)) ? CMIN : quo_neg;
        end else begin
            result = (quo_x > CMAX_X) ? CMAX : quo_x[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '1;
            r_run  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_pend <= n_pend;
            if (start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (last_step) begin
                r_run <= 1'b0;
            end else if (r_run) begin
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_axis <= n_axis;
            r_rem  <= '0;
            r_quo  <= '0;
            r_mag  <= den_abs[W-1:0];
            r_neg  <= den[W];
            r_zero <= (den == '0);
        end else if (r_run) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
        if (last_step) begin
            o_inv[r_axis] <= result;
        end
    end

    assign o_busy = r_run || (|r_pend);

endmodule

// ===== rtl/ray_box_nearest_hit.sv =====
// Top level: ray against a stream of axis-aligned boxes, nearest slab hit.
//
// Software writes the ray through the config port (i_cfg_we, i_cfg_idx,
// i_cfg_data) while the block is idle; indexes past max_distance are ignored.
// Boxes arrive on the box channel (i_box_valid / o_box_ready), one beat per
// box, and one box can be taken in every cycle unless the divider or a
// stalled pipeline holds o_box_ready low. The beat flagged by i_last_box
// closes the pass and yields one beat on the result channel (o_res_valid /
// i_res_ready) through stages s1 to s5 and the output register. Other
// boxes produce no result beat. After reset and after each direction
// write a shared divider forms the reciprocal direction, one quotient bit
// per cycle, axis after axis; o_box_ready stays low while it is busy.
// Reset loads the register defaults and empties the pipeline. When the
// receiver stalls, a finished result holds in the output register; boxes
// that carry no result keep flowing, and a waiting last box holds its
// stage, which backs up into o_box_ready.
module ray_box_nearest_hit
    import rbnh_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]        i_cfg_data,
    input  logic                          i_box_valid,
    output logic                          o_box_ready,
    input  logic signed [COORD_WIDTH-1:0] i_box_min_x,
    input  logic signed [COORD_WIDTH-1:0] i_box_min_y,
    input  logic signed [COORD_WIDTH-1:0] i_box_min_z,
    input  logic signed [COORD_WIDTH-1:0] i_box_max_x,
    input  logic signed [COORD_WIDTH-1:0] i_box_max_y,
    input  logic signed [COORD_WIDTH-1:0] i_box_max_z,
    input  logic                          i_last_box,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output logic                          o_hit,
    output logic [COORD_WIDTH-2:0]        o_hit_distance,
    output logic signed [COORD_WIDTH-1:0] o_hit_x,
    output logic signed [COORD_WIDTH-1:0] o_hit_y,
    output logic signed [COORD_WIDTH-1:0] o_hit_z
);

    localparam int W  = COORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int DW = COORD_WIDTH - 1;
    localparam int PW = 2 * COORD_WIDTH;
    localparam int QW = 2 * COORD_WIDTH - FRAC_BITS;
    localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};
    localparam longint MAXD_FULL = longint'(MAX_DIST_INT) << FRAC_BITS;
    localparam longint MAXD_LIM  = (longint'(1) << (COORD_WIDTH - 1)) - 1;
    localparam logic [DW-1:0] MAXD_RST = DW'((MAXD_FULL > MAXD_LIM) ? MAXD_LIM : MAXD_FULL);
    localparam logic signed [W-1:0] DIRZ_RST = W'(-(longint'(1) << FRAC_BITS));

    function automatic logic signed [W-1:0] sat_sum(input logic signed [W:0] s);
        logic signed [W-1:0] r;
        if (s[W] != s[W-1]) begin
            r = s[W] ? CMIN : CMAX;
        end else begin
            r = s[W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [W-1:0] mulq(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
        logic signed [PW-1:0] ax;
        logic signed [PW-1:0] bx;
        logic signed [PW-1:0] p;
        logic signed [QW-1:0] q;
        logic signed [W-1:0]  r;
        ax = {{W{a[W-1]}}, a};
        bx = {{W{b[W-1]}}, b};
        p  = ax * bx;
        q  = p[PW-1:F];
        if (p[PW-1] && (|p[F-1:0])) begin
            q = q + {{(QW-1){1'b0}}, 1'b1};
        end
        if ((&q[QW-1:W-1]) || !(|q[QW-1:W-1])) begin
            r = q[W-1:0];
        end else begin
            r = q[QW-1] ? CMIN : CMAX;
        end
        return r;
    endfunction

    // configuration
    logic signed [W-1:0]  r_origin [NUM_AXES];
    logic signed [W-1:0]  r_dir [NUM_AXES];
    logic [DW-1:0]        r_maxd;
    logic [NUM_AXES-1:0]  dir_wr;
    logic signed [W-1:0]  inv [NUM_AXES];
    logic                 recip_busy;

    assign dir_wr[0] = i_cfg_we && (i_cfg_idx == REG_DIR_X);
    assign dir_wr[1] = i_cfg_we && (i_cfg_idx == REG_DIR_Y);
    assign dir_wr[2] = i_cfg_we && (i_cfg_idx == REG_DIR_Z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin[0] <= '0;
            r_origin[1] <= '0;
            r_origin[2] <= '0;
            r_dir[0]    <= '0;
            r_dir[1]    <= '0;
            r_dir[2]    <= DIRZ_RST;
            r_maxd      <= MAXD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ORIGIN_X: r_origin[0] <= i_cfg_data;
                REG_ORIGIN_Y: r_origin[1] <= i_cfg_data;
                REG_ORIGIN_Z: r_origin[2] <= i_cfg_data;
                REG_DIR_X:    r_dir[0]    <= i_cfg_data;
                REG_DIR_Y:    r_dir[1]    <= i_cfg_data;
                REG_DIR_Z:    r_dir[2]    <= i_cfg_data;
                REG_MAX_DIST: r_maxd      <= i_cfg_data[DW-1:0];
                default: begin
                end
            endcase
        end
    end

    rbnh_recip #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_recip (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_dir    (r_dir),
        .i_dir_wr (dir_wr),
        .o_inv    (inv),
        .o_busy   (recip_busy)
    );

    // pipeline registers
    logic                r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_s5_vld, r_out_vld;
    logic                r_s1_last, r_s2_last, r_s3_last;
    logic signed [W-1:0] r_s1_lo [NUM_AXES];
    logic signed [W-1:0] r_s1_hi [NUM_AXES];
    logic signed [W-1:0] r_s2_lo [NUM_AXES];
    logic signed [W-1:0] r_s2_hi [NUM_AXES];
    logic signed [W-1:0] r_s3_t0 [NUM_AXES];
    logic signed [W-1:0] r_s3_t1 [NUM_AXES];
    logic                r_s4_hit, r_s5_hit;
    logic [DW-1:0]       r_s4_best, r_s5_best;
    logic signed [W-1:0] r_s5_prod [NUM_AXES];

    // pass state
    logic                r_in_pass;
    logic                r_found;
    logic [DW-1:0]       r_best;

    // flow control
    logic out_free, s5_free, s4_free, s3_free, s2_free, s1_free;
    logic s5_go, s4_go, s3_go, s2_go, s1_go, box_acc;

    assign out_free = !r_out_vld || i_res_ready;
    assign s5_go    = r_s5_vld && out_free;
    assign s5_free  = !r_s5_vld || out_free;
    assign s4_go    = r_s4_vld && s5_free;
    assign s4_free  = !r_s4_vld || s5_free;
    assign s3_free  = !r_s3_vld || !r_s3_last || s4_free;
    assign s3_go    = r_s3_vld && s3_free;
    assign s2_free  = !r_s2_vld || s3_free;
    assign s2_go    = r_s2_vld && s3_free;
    assign s1_free  = !r_s1_vld || s2_free;
    assign s1_go    = r_s1_vld && s2_free;

    assign o_box_ready = s1_free && !recip_busy;
    assign box_acc     = i_box_valid && o_box_ready;

    // slab verdict
    logic signed [W-1:0] mn [NUM_AXES];
    logic signed [W-1:0] mx [NUM_AXES];
    logic signed [W-1:0] tnear, tfar;
    logic [DW-1:0]       base;
    logic                base_found;
    logic                hit_now;
    logic [DW-1:0]       new_best;
    logic                new_found;

    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            mn[i] = (r_s3_t0[i] < r_s3_t1[i]) ? r_s3_t0[i] : r_s3_t1[i];
            mx[i] = (r_s3_t0[i] < r_s3_t1[i]) ? r_s3_t1[i] : r_s3_t0[i];
        end
        tnear = mn[0];
        tfar  = mx[0];
        for (int i = 1; i < NUM_AXES; i++) begin
            if (mn[i] > tnear) begin
                tnear = mn[i];
            end
            if (mx[i] < tfar) begin
                tfar = mx[i];
            end
        end
    end

    assign base       = r_in_pass ? r_best : r_maxd;
    assign base_found = r_in_pass && r_found;
    assign hit_now    = (tnear < tfar) && !tnear[W-1] && (|tnear) &&
                        (tnear < $signed({1'b0, base}));
    assign new_best   = hit_now ? tnear[DW-1:0] : base;
    assign new_found  = hit_now || base_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_s5_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_in_pass <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_vld <= box_acc;
            end
            if (s2_free) begin
                r_s2_vld <= s1_go;
            end
            if (s3_free) begin
                r_s3_vld <= s2_go;
            end
            if (s4_free) begin
                r_s4_vld <= s3_go && r_s3_last;
            end
            if (s5_free) begin
                r_s5_vld <= s4_go;
            end
            if (out_free) begin
                r_out_vld <= s5_go;
            end
            if (s3_go) begin
                r_in_pass <= !r_s3_last;
                r_found   <= new_found && !r_s3_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (box_acc) begin
            r_s1_lo[0] <= i_box_min_x;
            r_s1_lo[1] <= i_box_min_y;
            r_s1_lo[2] <= i_box_min_z;
            r_s1_hi[0] <= i_box_max_x;
            r_s1_hi[1] <= i_box_max_y;
            r_s1_hi[2] <= i_box_max_z;
            r_s1_last  <= i_last_box;
        end
        if (s1_go) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r_s2_lo[i] <= sat_sum({r_s1_lo[i][W-1], r_s1_lo[i]} -
                                      {r_origin[i][W-1], r_origin[i]});
                r_s2_hi[i] <= sat_sum({r_s1_hi[i][W-1], r_s1_hi[i]} -
                                      {r_origin[i][W-1], r_origin[i]});
            end
            r_s2_last <= r_s1_last;
        end
        if (s2_go) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r_s3_t0[i] <= mulq(r_s2_lo[i], inv[i]);
                r_s3_t1[i] <= mulq(r_s2_hi[i], inv[i]);
            end
            r_s3_last <= r_s2_last;
        end
        if (s3_go) begin
            r_best <= new_best;
            if (r_s3_last) begin
                r_s4_hit  <= new_found;
                r_s4_best <= new_best;
            end
        end
        if (s4_go) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r_s5_prod[i] <= mulq(r_dir[i], $signed({1'b0, r_s4_best}));
            end
            r_s5_hit  <= r_s4_hit;
            r_s5_best <= r_s4_best;
        end
        if (s5_go) begin
            o_hit <= r_s5_hit;
            if (r_s5_hit) begin
                o_hit_distance <= r_s5_best;
                o_hit_x <= sat_sum({r_origin[0][W-1], r_origin[0]} +
                                   {r_s5_prod[0][W-1], r_s5_prod[0]});
                o_hit_y <= sat_sum({r_origin[1][W-1], r_origin[1]} +
                                   {r_s5_prod[1][W-1], r_s5_prod[1]});
                o_hit_z <= sat_sum({r_origin[2][W-1], r_origin[2]} +
                                   {r_s5_prod[2][W-1], r_s5_prod[2]});
            end else begin
                o_hit_distance <= '0;
                o_hit_x        <= '0;
                o_hit_y        <= '0;
                o_hit_z        <= '0;
            end
        end
    end

    assign o_res_valid = r_out_vld;

endmodule
